// ----- hw/rtl/rpa_pkg.sv -----
// Shared types, widths and codes for the reference-counted page allocator.
// No dependencies; imported by every module of the block.
package rpa_pkg;

	localparam int MAX_PAGES  = 4096;
	localparam int PAGE_BYTES = 4096;

	localparam int IDX_W   = $clog2(MAX_PAGES);
	localparam int TOP_W   = IDX_W + 1;
	localparam int OFS_W   = $clog2(PAGE_BYTES);
	localparam int ADDR_W  = 56;
	localparam int BASE_W  = 44;
	localparam int NCNT_W  = 13;
	localparam int CNT_W   = 16;
	localparam int PFN_W   = ADDR_W - OFS_W;
	localparam int CMP_W   = ((PFN_W > BASE_W) ? PFN_W : BASE_W) + 1;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 3;
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// operation codes
	localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
	localparam logic [OP_W-1:0] OP_FREE    = 3'd2;
	localparam logic [OP_W-1:0] OP_REF_INC = 3'd3;
	localparam logic [OP_W-1:0] OP_REF_GET = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_OOM       = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_ADDR  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DBL_FREE  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 3'd4;
	localparam logic [STAT_W-1:0] STAT_SAT       = 3'd5;

	// register select, taken from paddr bit 3 (registers sit 8 bytes apart)
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] page_address;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] result_address;
		logic [CNT_W-1:0]  ref_count;
	} rsp_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [NCNT_W-1:0] pages;   // page count clamped to MAX_PAGES
	} cfg_t;

endpackage

// ----- hw/rtl/rpa_regs.sv -----
// APB register file: region base page frame and page count.
// Depends on rpa_pkg; supplies the clamped configuration to the top level.
module rpa_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpa_pkg::PADDR_W-1:0] paddr,
	input  logic [rpa_pkg::PDATA_W-1:0] pwdata,
	output logic [rpa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output rpa_pkg::cfg_t               cfg
);
	import rpa_pkg::*;

	logic [BASE_W-1:0] base_q;
	logic [NCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				REG_BASE:  base_q  <= pwdata[BASE_W-1:0];
				REG_COUNT: count_q <= pwdata[NCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3])
			REG_BASE:  prdata = PDATA_W'(base_q);
			REG_COUNT: prdata = PDATA_W'(count_q);
			default: ;
		endcase
	end

	assign pready    = 1'b1;
	assign cfg.base  = base_q;
	assign cfg.pages = (count_q > NCNT_W'(MAX_PAGES)) ? NCNT_W'(MAX_PAGES) : count_q;

endmodule

// ----- hw/rtl/refcounted_page_allocator.sv -----
// Reference-counted page allocator top level: free-page stack and count memories.
// Depends on rpa_pkg and rpa_regs.
//
//   channel  | direction | handshake            | beat
//   req      | in        | req_valid/req_ready  | op, page_address
//   rsp      | out       | rsp_valid/rsp_ready  | status, result_address, ref_count
//   apb      | in        | psel/penable/pready  | register write or read
//
// Alloc, free, ref_inc and ref_get: accept issues the memory reads, then the execute
// state modifies, writes back and loads the response register.
// Init zeroes all MAX_PAGES count entries and fills the first cfg.pages stack entries, one per cycle.
// After reset a clearing pass zeroes all MAX_PAGES counts; req_ready is low.
// A full response register holds the block in its write-back cycle until rsp_ready.
module refcounted_page_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  rpa_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output rpa_pkg::rsp_t               rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpa_pkg::PADDR_W-1:0] paddr,
	input  logic [rpa_pkg::PDATA_W-1:0] pwdata,
	output logic [rpa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import rpa_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	cfg_t cfg;

	rpa_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	logic [1:0]       state_q;
	logic             sweep_init_q;
	logic [IDX_W-1:0] sweep_cnt_q;
	logic [TOP_W-1:0] top_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [OP_W-1:0]   op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              ok_s1;

	logic [CNT_W-1:0] ref_mem [MAX_PAGES];
	logic [IDX_W-1:0] stk_mem [MAX_PAGES];
	logic [CNT_W-1:0] ref_rd_s1;
	logic [IDX_W-1:0] stk_rd_s1;

	// address check on the incoming beat
	logic [PFN_W-1:0] req_pfn;
	logic [CMP_W-1:0] req_diff;
	logic             req_ok;

	assign req_pfn  = req.page_address[ADDR_W-1:OFS_W];
	assign req_diff = CMP_W'(req_pfn) - CMP_W'(cfg.base);
	assign req_ok   = (req.page_address[OFS_W-1:0] == '0) && !req_diff[CMP_W-1]
	                  && (req_diff[CMP_W-2:0] < (CMP_W-1)'(cfg.pages));

	logic accept, fire, sweep_end, sweep;
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign fire      = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	assign sweep     = (state_q == ST_SWEEP);
	assign sweep_end = sweep && (sweep_cnt_q == {IDX_W{1'b1}});

	// write-back decision for the item in flight
	rsp_t             rsp_d;
	logic             ref_we, push, pop;
	logic [CNT_W-1:0] ref_wd;
	logic [IDX_W-1:0] ref_wa;
	logic [BASE_W-1:0] alloc_pfn;

	assign alloc_pfn = cfg.base + BASE_W'(stk_rd_s1);

	always_comb begin
		rsp_d.status         = STAT_OK;
		rsp_d.result_address = addr_s1;
		rsp_d.ref_count      = '0;
		ref_we = 1'b0;
		ref_wd = '0;
		ref_wa = idx_s1;
		push   = 1'b0;
		pop    = 1'b0;
		case (op_s1)
			OP_ALLOC: begin
				if (top_q == '0) begin
					rsp_d.status         = STAT_OOM;
					rsp_d.result_address = '0;
				end else begin
					pop    = 1'b1;
					ref_we = 1'b1;
					ref_wa = stk_rd_s1;
					ref_wd = CNT_W'(1);
					rsp_d.ref_count      = CNT_W'(1);
					rsp_d.result_address = ADDR_W'({alloc_pfn, {OFS_W{1'b0}}});
				end
			end
			OP_FREE: begin
				if (!ok_s1) begin
					rsp_d.status = STAT_BAD_ADDR;
				end else if (ref_rd_s1 == '0) begin
					rsp_d.status = STAT_DBL_FREE;
				end else begin
					ref_we = 1'b1;
					ref_wd = ref_rd_s1 - CNT_W'(1);
					rsp_d.ref_count = ref_wd;
					push = (ref_wd == '0);
				end
			end
			OP_REF_INC: begin
				if (!ok_s1) begin
					rsp_d.status = STAT_BAD_ADDR;
				end else if (ref_rd_s1 == '0) begin
					rsp_d.status = STAT_NOT_ALLOC;
				end else if (ref_rd_s1 == CNT_MAX) begin
					rsp_d.status    = STAT_SAT;
					rsp_d.ref_count = CNT_MAX;
				end else begin
					ref_we = 1'b1;
					ref_wd = ref_rd_s1 + CNT_W'(1);
					rsp_d.ref_count = ref_wd;
				end
			end
			OP_REF_GET: begin
				if (!ok_s1) begin
					rsp_d.status = STAT_BAD_ADDR;
				end else begin
					rsp_d.ref_count = ref_rd_s1;
				end
			end
			default: ;
		endcase
	end

	// memory ports
	logic             ref_we_x, stk_we_x;
	logic [IDX_W-1:0] ref_wa_x, ref_ra, stk_wa_x, stk_wd_x, stk_ra;
	logic [CNT_W-1:0] ref_wd_x;
	logic             stk_full;

	assign stk_full = (top_q >= TOP_W'(MAX_PAGES));
	assign ref_we_x = sweep || (fire && ref_we);
	assign ref_wa_x = sweep ? sweep_cnt_q : ref_wa;
	assign ref_wd_x = sweep ? '0 : ref_wd;
	// hold the read address during a stalled write-back so the read data stays put
	assign ref_ra   = (state_q == ST_IDLE) ? req_diff[IDX_W-1:0] : idx_s1;
	assign stk_we_x = sweep ? (sweep_init_q && (TOP_W'(sweep_cnt_q) < TOP_W'(cfg.pages)))
	                        : (fire && push && !stk_full);
	assign stk_wa_x = sweep ? sweep_cnt_q : top_q[IDX_W-1:0];
	assign stk_wd_x = sweep ? sweep_cnt_q : idx_s1;
	assign stk_ra   = IDX_W'(top_q - TOP_W'(1));

	always_ff @(posedge clk) begin
		if (ref_we_x) begin
			ref_mem[ref_wa_x] <= ref_wd_x;
		end
		ref_rd_s1 <= ref_mem[ref_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we_x) begin
			stk_mem[stk_wa_x] <= stk_wd_x;
		end
		stk_rd_s1 <= stk_mem[stk_ra];
	end

	// item stage registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.op;
			addr_s1 <= req.page_address;
			idx_s1  <= req_diff[IDX_W-1:0];
			ok_s1   <= req_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_init_q <= 1'b0;
			sweep_cnt_q  <= '0;
			top_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.op == OP_INIT) begin
							state_q      <= ST_SWEEP;
							sweep_init_q <= 1'b1;
							sweep_cnt_q  <= '0;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + IDX_W'(1);
					if (sweep_end) begin
						sweep_init_q <= 1'b0;
						if (sweep_init_q) begin
							top_q   <= TOP_W'(cfg.pages);
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
						if (pop) begin
							top_q <= top_q - TOP_W'(1);
						end else if (push && !stk_full) begin
							top_q <= top_q + TOP_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/rpa_chk.sv -----
// Port-level checks for the page allocator, and the bind that attaches them.
// Depends on rpa_pkg and refcounted_page_allocator.
module rpa_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input rpa_pkg::rsp_t               rsp,
	input logic                        pready
);
	import rpa_pkg::*;

	// a response waiting for the sink holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	// one item at a time: an accepted request closes the input in the cycle after it
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous item in flight");

	a_oom_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_OOM |-> rsp.result_address == '0 && rsp.ref_count == '0)
		else $error("out-of-memory response carries address or count");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == STAT_OK || rsp.status == STAT_OOM
		|| rsp.status == STAT_BAD_ADDR || rsp.status == STAT_DBL_FREE
		|| rsp.status == STAT_NOT_ALLOC || rsp.status == STAT_SAT)
		else $error("undefined status code");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind refcounted_page_allocator rpa_chk u_rpa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp),
	.pready   (pready)
);
